>>> rtl/vrm_pkg.sv
package vrm_pkg;

	localparam int FRAC_BITS = 10;
	localparam int GRID_BITS = 5;
	localparam int GRID_SIDE = 1 << GRID_BITS;
	localparam int ADDR_W    = 3 * GRID_BITS;
	localparam int CELL_CNT  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
	localparam int ORG_W     = 15;
	localparam int DIR_W     = 14;
	localparam int MAG_W     = 14;
	localparam int LEN_W     = 14;
	localparam int TN_W      = LEN_W + 1;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int CELL_W    = 8;

	// axis codes
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	localparam logic ST_OK      = 1'b0;
	localparam logic ST_ZERODIR = 1'b1;

	typedef logic [CELL_W-1:0] cell_t;
	typedef logic [TN_W-1:0]   tn_t;

endpackage

>>> rtl/vrm_ram.sv
module vrm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/vrm_sqrt.sv
module vrm_sqrt import vrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [PROD_W-1:0] radicand,
	output logic              done,
	output logic [LEN_W-1:0]  root
);

	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] bit_q;
	logic [PROD_W-1:0] root_q;
	logic              run_q;
	logic [PROD_W-1:0] trial;

	// one add and compare per iteration
	assign trial = root_q + bit_q;
	assign root  = root_q[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[1:0] != 2'b00) begin
				run_q <= 1'b0;
				done  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= PROD_W'(1) << (PROD_W - 2);
		end else if (run_q) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> rtl/vrm_div.sv
module vrm_div import vrm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [PROD_W-1:0] dividend,
	input  logic [MAG_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [MAG_W:0]    rem_q;
	logic [PROD_W-1:0] q_q;
	logic [MAG_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W:0]    shifted;

	// restoring, one quotient bit a cycle
	assign shifted  = {rem_q[MAG_W-1:0], q_q[PROD_W-1]};
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			q_q   <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (shifted >= {1'b0, dvs_q}) begin
				rem_q <= shifted - {1'b0, dvs_q};
				q_q   <= {q_q[PROD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[PROD_W-2:0], 1'b0};
			end
		end
	end

endmodule

>>> rtl/voxel_ray_march_top.sv
// Voxel ray caster over a 32x32x32 one-bit occupancy map.
// Command port: an item is taken on a clock edge with start high and busy
// low. opcode 0 writes one cell (voxel_x/y/z, voxel_solid) in that same
// cycle; busy does not rise and no result follows. opcode 1 casts a ray
// from origin_x/y/z (unsigned Q5.10) along dir_x/y/z (signed Q3.10);
// the direction length is the search limit.
// Each cast gives one result, held on the result ports for one cycle with
// done high; the receiver cannot stall, so done is a plain strobe.
// Steps of a cast: the squared length through the shared 14x14 multiplier,
// the iterative square root, then per moving axis the first crossing
// distance (multiply, then the restoring divider), then per cell stepped
// a select, an occupancy read and the next crossing distance. The divider
// sets the pace of a cast; busy is high throughout.
// A zero direction returns after the square root with status set.
// After reset the map is cleared one cell a cycle: busy stays high until
// every cell is cleared, before the first transfer is taken.
module voxel_ray_march_top import vrm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    opcode,
	input  logic [GRID_BITS-1:0]    voxel_x,
	input  logic [GRID_BITS-1:0]    voxel_y,
	input  logic [GRID_BITS-1:0]    voxel_z,
	input  logic                    voxel_solid,
	input  logic [ORG_W-1:0]        origin_x,
	input  logic [ORG_W-1:0]        origin_y,
	input  logic [ORG_W-1:0]        origin_z,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic signed [DIR_W-1:0] dir_z,
	output logic                    done,
	output logic                    status,
	output logic                    hit,
	output logic [GRID_BITS-1:0]    hit_x,
	output logic [GRID_BITS-1:0]    hit_y,
	output logic [GRID_BITS-1:0]    hit_z,
	output logic [1:0]              hit_axis,
	output logic [LEN_W-1:0]        distance
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SQM  = 4'd2;
	localparam logic [3:0] S_SQA  = 4'd3;
	localparam logic [3:0] S_SQRT = 4'd4;
	localparam logic [3:0] S_TI   = 4'd5;
	localparam logic [3:0] S_TM   = 4'd6;
	localparam logic [3:0] S_TD   = 4'd7;
	localparam logic [3:0] S_SEL  = 4'd8;
	localparam logic [3:0] S_RD   = 4'd9;
	localparam logic [3:0] S_CHK  = 4'd10;

	localparam int OFF_W = CELL_W + FRAC_BITS + 1;

	logic [3:0]          state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [ORG_W-1:0]    org_q [3];
	logic [MAG_W-1:0]    mag_q [3];
	logic [2:0]          act_q;
	logic [2:0]          neg_q;
	cell_t               cell_q [3];
	cell_t               nb_q [3];
	tn_t                 tn_q [3];
	logic [LEN_W-1:0]    len_q;
	logic [PROD_W-1:0]   sq_q;
	logic [1:0]          ax_q;
	logic                init_q;

	logic [MAG_W-1:0]    mul_a, mul_b;
	logic [PROD_W-1:0]   mul_s1;

	logic                sqrt_go, sqrt_done;
	logic [LEN_W-1:0]    sqrt_root;
	logic                div_go, div_done;
	logic [PROD_W-1:0]   div_q;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic                ram_wdata, ram_rdata;

	logic [MAG_W-1:0]    mag_in [3];
	logic signed [DIR_W-1:0] dir_in [3];
	logic [ORG_W-1:0]    org_in [3];
	logic signed [OFF_W-1:0] off_full;
	logic [MAG_W-1:0]    off;
	logic                sel_ok;
	logic [1:0]          sel_ax;
	logic                in_grid;
	cell_t               step_v;
	tn_t                 tn_new;

	assign busy = (state_q != S_IDLE);

	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;
	assign org_in[0] = origin_x;
	assign org_in[1] = origin_y;
	assign org_in[2] = origin_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = dir_in[i][DIR_W-1] ? MAG_W'(-dir_in[i]) : MAG_W'(dir_in[i]);
		end
	end

	// offset from origin to the pending boundary of the working axis
	always_comb begin
		logic signed [OFF_W-1:0] bnd;
		logic signed [OFF_W-1:0] org;
		bnd = OFF_W'({{(OFF_W-CELL_W){nb_q[ax_q][CELL_W-1]}}, nb_q[ax_q]}) <<< FRAC_BITS;
		org = OFF_W'(org_q[ax_q]);
		off_full = neg_q[ax_q] ? (org - bnd) : (bnd - org);
		off = off_full[OFF_W-1] ? '0 : off_full[MAG_W-1:0];
	end

	// shared multiplier: squares of the direction, then offset times limit
	always_comb begin
		if (state_q == S_TI) begin
			mul_a = off;
			mul_b = len_q;
		end else begin
			mul_a = mag_q[ax_q];
			mul_b = mag_q[ax_q];
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mul_a * mul_b;
	end

	// nearest crossing; ties go to the lowest axis
	always_comb begin
		sel_ok = 1'b0;
		sel_ax = AX_X;
		for (int i = 0; i < 3; i++) begin
			if (act_q[i] && (!sel_ok || tn_q[i] < tn_q[sel_ax])) begin
				sel_ok = 1'b1;
				sel_ax = 2'(i);
			end
		end
	end

	assign step_v = neg_q[sel_ax] ? '1 : cell_t'(1);
	assign in_grid = (cell_q[0][CELL_W-1:GRID_BITS] == '0) &&
	                 (cell_q[1][CELL_W-1:GRID_BITS] == '0) &&
	                 (cell_q[2][CELL_W-1:GRID_BITS] == '0);
	assign tn_new = (div_q > PROD_W'(len_q)) ? (tn_t'(len_q) + 1'b1) : tn_t'(div_q);

	assign sqrt_go = (state_q == S_SQA) && (ax_q == AX_Z);
	assign div_go  = (state_q == S_TM);

	assign ram_we    = (state_q == S_CLR) ||
	                   ((state_q == S_IDLE) && start && (opcode == OP_WRITE));
	assign ram_waddr = (state_q == S_CLR) ? clr_q : {voxel_x, voxel_y, voxel_z};
	assign ram_wdata = (state_q == S_CLR) ? 1'b0 : voxel_solid;
	assign ram_raddr = {cell_q[0][GRID_BITS-1:0], cell_q[1][GRID_BITS-1:0],
	                    cell_q[2][GRID_BITS-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			done    <= 1'b0;
			ax_q    <= AX_X;
			init_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && opcode == OP_CAST) begin
						ax_q    <= AX_X;
						state_q <= S_SQM;
					end
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					if (ax_q == AX_Z) begin
						state_q <= S_SQRT;
					end else begin
						ax_q    <= ax_q + 1'b1;
						state_q <= S_SQM;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						if (sqrt_root == '0) begin
							done    <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							ax_q    <= AX_X;
							init_q  <= 1'b1;
							state_q <= act_q[0] ? S_TI : S_TD;
						end
					end
				end
				S_TI: state_q <= S_TM;
				S_TM: state_q <= S_TD;
				S_TD: begin
					// an idle axis in the first pass passes straight through
					if (div_done || (init_q && !act_q[ax_q])) begin
						if (init_q && ax_q != AX_Z) begin
							ax_q    <= ax_q + 1'b1;
							state_q <= act_q[ax_q + 1'b1] ? S_TI : S_TD;
						end else begin
							init_q  <= 1'b0;
							state_q <= S_SEL;
						end
					end
				end
				S_SEL: begin
					if (!sel_ok || tn_q[sel_ax] > tn_t'(len_q)) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ax_q    <= sel_ax;
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (in_grid && ram_rdata) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TI;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sq_q <= '0;
				for (int i = 0; i < 3; i++) begin
					org_q[i] <= org_in[i];
					mag_q[i] <= mag_in[i];
					act_q[i] <= (dir_in[i] != '0);
					neg_q[i] <= dir_in[i][DIR_W-1];
					cell_q[i] <= cell_t'(org_in[i] >> FRAC_BITS);
					nb_q[i]   <= cell_t'(org_in[i] >> FRAC_BITS) +
					             cell_t'(!dir_in[i][DIR_W-1] && dir_in[i] != '0);
				end
			end
			S_SQA: sq_q <= sq_q + mul_s1;
			S_SQRT: begin
				len_q <= sqrt_root;
				if (sqrt_done && sqrt_root == '0) begin
					status   <= ST_ZERODIR;
					hit      <= 1'b0;
					hit_x    <= '0;
					hit_y    <= '0;
					hit_z    <= '0;
					hit_axis <= AX_X;
					distance <= '0;
				end
			end
			S_TD: begin
				if (div_done) begin
					tn_q[ax_q] <= tn_new;
				end
			end
			S_SEL: begin
				cell_q[sel_ax] <= cell_q[sel_ax] + step_v;
				status   <= ST_OK;
				hit      <= 1'b0;
				hit_x    <= '0;
				hit_y    <= '0;
				hit_z    <= '0;
				hit_axis <= AX_X;
				distance <= len_q;
			end
			S_CHK: begin
				nb_q[ax_q] <= nb_q[ax_q] + (neg_q[ax_q] ? '1 : cell_t'(1));
				hit      <= 1'b1;
				hit_x    <= cell_q[0][GRID_BITS-1:0];
				hit_y    <= cell_q[1][GRID_BITS-1:0];
				hit_z    <= cell_q[2][GRID_BITS-1:0];
				hit_axis <= ax_q;
				distance <= tn_q[ax_q][LEN_W-1:0];
			end
			default: ;
		endcase
	end

	vrm_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go),
		.radicand (sq_q + mul_s1),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	vrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (mul_s1),
		.divisor  (mag_q[ax_q]),
		.done     (div_done),
		.quotient (div_q)
	);

	vrm_ram #(
		.WIDTH (1),
		.DEPTH (CELL_CNT)
	) u_occ (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
